>>> rtl/qs_pkg.sv
`timescale 1ns / 1ps
// Shared widths, the CORDIC arctangent table and the lane types of the slerp pipeline.
// Depends on nothing; quaternion_slerp, qs_cordic_cell and qs_div_cell import it.

package qs_pkg;

    // CORDIC datapath: x and y in units of 2^-20, angles in units of 2^-20 rad.
    localparam int CW           = 24;
    localparam int ZW           = 26;
    localparam int CORDIC_STEPS = 18;

    localparam logic signed [CW-1:0] C_GAIN = 24'sd636751;

    localparam logic signed [ZW-1:0] C_ATAN [CORDIC_STEPS] = '{
        26'sd823550, 26'sd486170, 26'sd256879, 26'sd130396, 26'sd65451, 26'sd32757,
        26'sd16383,  26'sd8192,   26'sd4096,   26'sd2048,   26'sd1024,  26'sd512,
        26'sd256,    26'sd128,    26'sd64,     26'sd32,     26'sd16,    26'sd8
    };

    // Final divider: numerator magnitude, divisor and quotient widths.
    localparam int NUMW  = 42;
    localparam int DW    = 24;
    localparam int QW    = 17;

    typedef logic [3:0][NUMW-1:0] t_rem4;
    typedef logic [3:0][QW-1:0]   t_quo4;

    // Per-item flags that travel beside the divider cells.
    typedef struct packed {
        logic [3:0] neg;
        logic [3:0] ovf;
        logic       zero;
    } t_div_flags;

endpackage

>>> rtl/quaternion_slerp.sv
`timescale 1ns / 1ps
// Quaternion slerp in fixed point: Q2.14 components, Q1.15 blend, saturated Q2.14 result.
// Depends on qs_pkg, qs_delay, qs_sqrt_cell, qs_cordic_cell and qs_div_cell.
//
// The block takes one item every clock cycle while it is not held, and keeps no state between
// items. An item passes through a chain of cells in turn: a 21-step square root, 18 CORDIC
// vectoring steps for the arc angle, 18 CORDIC rotation steps for the sines and 17 divider
// steps. A finished item waits in an output register with a skid register behind it, so
// input is taken while an item waits; when both hold items the whole pipeline holds. A dot
// magnitude above the threshold in r_thr (or at one, or the sine of the arc not positive)
// selects the normalised linear blend.

module quaternion_slerp import qs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic        [14:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_first_x,
    input  logic signed [15:0] i_first_y,
    input  logic signed [15:0] i_first_z,
    input  logic signed [15:0] i_first_w,
    input  logic signed [15:0] i_second_x,
    input  logic signed [15:0] i_second_y,
    input  logic signed [15:0] i_second_z,
    input  logic signed [15:0] i_second_w,
    input  logic        [15:0] i_blend,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic signed [15:0] o_out_w
);

    // Stage numbering: stage 1 holds the accepted item.
    localparam int SQY_N = 21;
    localparam int SQM_N = 24;
    localparam int DIV_N = QW;
    localparam int S_Y   = 7 + SQY_N;
    localparam int S_TH  = S_Y + CORDIC_STEPS;
    localparam int S_SIN = S_TH + 2 + CORDIC_STEPS;
    localparam int S_MAG = 10 + SQM_N;
    localparam int S_Q   = 72 + DIV_N;
    localparam int LAT   = S_Q + 1;

    localparam logic [14:0] THR_RESET = 15'd16368;

    // ------------------------------------------------------------------
    // Control: threshold register, valid line and output stage.
    // ------------------------------------------------------------------
    logic [14:0]      r_thr;
    logic [LAT-1:0]   r_vld;
    logic             r_ov;
    logic             r_sv;
    logic [3:0][15:0] r_od;
    logic [3:0][15:0] r_sd;
    logic [3:0][15:0] r_tail;
    logic             en;
    logic             accept;
    logic             take;

    assign en          = !r_sv;
    assign o_in_ready  = en;
    assign accept      = i_in_valid && en;
    assign take        = r_ov && i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_x     = r_od[0];
    assign o_out_y     = r_od[1];
    assign o_out_z     = r_od[2];
    assign o_out_w     = r_od[3];

    // The threshold is written directly whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Valid bits follow the items down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (en) begin
            if (r_vld[LAT-1]) begin
                if (!r_ov || take) begin
                    r_ov <= 1'b1;
                end else begin
                    r_sv <= 1'b1;
                end
            end else if (take) begin
                r_ov <= 1'b0;
            end
        end else if (take) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_vld[LAT-1]) begin
                if (!r_ov || take) begin
                    r_od <= r_tail;
                end else begin
                    r_sd <= r_tail;
                end
            end
        end else if (take) begin
            r_od <= r_sd;
        end
    end

    // ------------------------------------------------------------------
    // Front end: dot product, shortest-arc flip and path decision.
    // ------------------------------------------------------------------
    logic [3:0][15:0] r1_a;
    logic [3:0][15:0] r1_b;
    logic [15:0]      r1_t;
    logic [3:0][31:0] r2_p;
    logic [33:0]      r3_dot;
    logic [3:0][15:0] b_s3;
    logic [15:0]      t_s4;
    logic [3:0][15:0] a_s5;
    logic [18:0]      r4_dq;
    logic [3:0][16:0] r4_b;
    logic             r5_lin0;
    logic [19:0]      r5_x;
    logic [3:0][16:0] r5_b;
    logic [15:0]      r5_t;
    logic [15:0]      r5_tc;
    logic [33:0]      dabs;

    // Accepted item, with the blend saturated at one.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a <= {i_first_w, i_first_z, i_first_y, i_first_x};
            r1_b <= {i_second_w, i_second_z, i_second_y, i_second_x};
            r1_t <= (i_blend > 16'd32768) ? 16'd32768 : i_blend;
        end
    end

    qs_delay #(.W(64), .DEPTH(2)) u_dly_b3 (.i_clk, .i_en(en), .i_d(r1_b), .o_q(b_s3));
    qs_delay #(.W(16), .DEPTH(3)) u_dly_t4 (.i_clk, .i_en(en), .i_d(r1_t), .o_q(t_s4));
    qs_delay #(.W(64), .DEPTH(4)) u_dly_a5 (.i_clk, .i_en(en), .i_d(r1_a), .o_q(a_s5));

    assign dabs = r3_dot[33] ? (34'd0 - r3_dot) : r3_dot;

    // Products, their sum, the dot magnitude, the flipped second quaternion and the path flag.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r2_p[i] <= 32'($signed(r1_a[i]) * $signed(r1_b[i]));
            end
            r3_dot <= 34'($signed(r2_p[0])) + 34'($signed(r2_p[1]))
                    + 34'($signed(r2_p[2])) + 34'($signed(r2_p[3]));
            r4_dq  <= dabs[32:14];
            for (int i = 0; i < 4; i++) begin
                r4_b[i] <= r3_dot[33] ? (17'd0 - {b_s3[i][15], b_s3[i]})
                                      : {b_s3[i][15], b_s3[i]};
            end
            r5_lin0 <= (r4_dq > {4'd0, r_thr}) || (r4_dq >= 19'd16384);
            r5_x    <= {r4_dq[13:0], 6'd0};
            r5_b    <= r4_b;
            r5_t    <= t_s4;
            r5_tc   <= 16'd32768 - t_s4;
        end
    end

    // ------------------------------------------------------------------
    // Linear blend and its magnitude.
    // ------------------------------------------------------------------
    logic [3:0][31:0] r6_la;
    logic [3:0][31:0] r6_lb;
    logic [3:0][24:0] r7_c;
    logic [3:0][47:0] r8_cc;
    logic [47:0]      r9_s01;
    logic [47:0]      r9_s23;
    logic [47:0]      r10_sum;
    logic [32:0]      lsum [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lsum[i] = 33'($signed(r6_la[i])) + 33'($signed(r6_lb[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r6_la[i] <= 32'($signed(a_s5[i]) * $signed({1'b0, r5_tc}));
                r6_lb[i] <= 32'($signed(r5_b[i]) * $signed({1'b0, r5_t}));
                r7_c[i]  <= lsum[i][32:8];
                r8_cc[i] <= 48'($signed(r7_c[i]) * $signed(r7_c[i]));
            end
            r9_s01  <= r8_cc[0] + r8_cc[1];
            r9_s23  <= r8_cc[2] + r8_cc[3];
            r10_sum <= r9_s01 + r9_s23;
        end
    end

    // Magnitude square root, one bit per cell.
    logic [47:0] sqm_v [SQM_N+1];
    logic [47:0] sqm_r [SQM_N+1];

    assign sqm_v[0] = r10_sum;
    assign sqm_r[0] = '0;

    for (genvar k = 0; k < SQM_N; k++) begin : g_sqm
        qs_sqrt_cell #(.W(48), .NSTEP(SQM_N), .STEP(k)) u_cell (
            .i_clk, .i_en(en),
            .i_v(sqm_v[k]), .i_r(sqm_r[k]),
            .o_v(sqm_v[k+1]), .o_r(sqm_r[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Arc angle: sqrt(1 - dot^2) then CORDIC vectoring.
    // ------------------------------------------------------------------
    logic [39:0] r6_xx;
    logic [40:0] r7_v;
    logic [41:0] sqy_v [SQY_N+1];
    logic [41:0] sqy_r [SQY_N+1];
    logic [19:0] x_sy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_xx <= 40'(r5_x * r5_x);
            r7_v  <= 41'h100_0000_0000 - 41'(r6_xx);
        end
    end

    assign sqy_v[0] = 42'(r7_v);
    assign sqy_r[0] = '0;

    for (genvar k = 0; k < SQY_N; k++) begin : g_sqy
        qs_sqrt_cell #(.W(42), .NSTEP(SQY_N), .STEP(k)) u_cell (
            .i_clk, .i_en(en),
            .i_v(sqy_v[k]), .i_r(sqy_r[k]),
            .o_v(sqy_v[k+1]), .o_r(sqy_r[k+1])
        );
    end

    qs_delay #(.W(20), .DEPTH(S_Y-5)) u_dly_x (.i_clk, .i_en(en), .i_d(r5_x), .o_q(x_sy));

    logic signed [CW-1:0] vx [CORDIC_STEPS+1];
    logic signed [CW-1:0] vy [CORDIC_STEPS+1];
    logic signed [ZW-1:0] vz [CORDIC_STEPS+1];

    assign vx[0] = CW'(x_sy);
    assign vy[0] = CW'(sqy_r[SQY_N][20:0]);
    assign vz[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        qs_cordic_cell #(.STEP(k), .VECTORING(1'b1)) u_cell (
            .i_clk, .i_en(en),
            .i_x(vx[k]), .i_y(vy[k]), .i_z(vz[k]),
            .o_x(vx[k+1]), .o_y(vy[k+1]), .o_z(vz[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Scaled angles and the three sines.
    // ------------------------------------------------------------------
    logic [15:0]          t_th;
    logic [15:0]          tc_th;
    logic [ZW-1:0]        th_c;
    logic [ZW-1:0]        r47_th;
    logic [39:0]          r47_p0;
    logic [39:0]          r47_p1;
    logic signed [ZW-1:0] r48_th;
    logic signed [ZW-1:0] r48_ang0;
    logic signed [ZW-1:0] r48_ang1;

    qs_delay #(.W(32), .DEPTH(S_TH-5)) u_dly_t (
        .i_clk, .i_en(en), .i_d({r5_t, r5_tc}), .o_q({t_th, tc_th})
    );

    // Negative angles are clamped to zero.
    assign th_c = vz[CORDIC_STEPS][ZW-1] ? '0 : vz[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r47_th   <= th_c;
            r47_p0   <= 40'(th_c[ZW-2:0] * tc_th);
            r47_p1   <= 40'(th_c[ZW-2:0] * t_th);
            r48_th   <= r47_th;
            r48_ang0 <= ZW'((r47_p0 + 40'd16384) >> 15);
            r48_ang1 <= ZW'((r47_p1 + 40'd16384) >> 15);
        end
    end

    logic signed [CW-1:0] rx [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] ry [3][CORDIC_STEPS+1];
    logic signed [ZW-1:0] rz [3][CORDIC_STEPS+1];

    assign rz[0][0] = r48_th;
    assign rz[1][0] = r48_ang0;
    assign rz[2][0] = r48_ang1;

    for (genvar j = 0; j < 3; j++) begin : g_sin
        assign rx[j][0] = C_GAIN;
        assign ry[j][0] = '0;
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
            qs_cordic_cell #(.STEP(k), .VECTORING(1'b0)) u_cell (
                .i_clk, .i_en(en),
                .i_x(rx[j][k]), .i_y(ry[j][k]), .i_z(rz[j][k]),
                .o_x(rx[j][k+1]), .o_y(ry[j][k+1]), .o_z(rz[j][k+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Weighted sums and selection between slerp and the linear blend.
    // ------------------------------------------------------------------
    logic [3:0][15:0]     a_sin;
    logic [3:0][16:0]     b_sin;
    logic                 lin0_sin;
    logic [3:0][24:0]     c_sel;
    logic [23:0]          mag_sel;
    logic signed [CW-1:0] st;
    logic [3:0][41:0]     r67_ps0;
    logic [3:0][41:0]     r67_ps1;
    logic [CW-1:0]        r67_st;
    logic                 r67_lin;
    logic [3:0][41:0]     r68_n;
    logic [CW-1:0]        r68_st;
    logic                 r68_lin;
    t_rem4                r69_n;
    logic [DW-1:0]        r69_d;
    logic                 r69_zero;

    qs_delay #(.W(64), .DEPTH(S_SIN-5)) u_dly_a (.i_clk, .i_en(en), .i_d(a_s5), .o_q(a_sin));
    qs_delay #(.W(68), .DEPTH(S_SIN-5)) u_dly_b (.i_clk, .i_en(en), .i_d(r5_b), .o_q(b_sin));
    qs_delay #(.W(1), .DEPTH(S_SIN-5)) u_dly_l (
        .i_clk, .i_en(en), .i_d(r5_lin0), .o_q(lin0_sin)
    );
    qs_delay #(.W(100), .DEPTH(S_SIN+2-7)) u_dly_c (
        .i_clk, .i_en(en), .i_d(r7_c), .o_q(c_sel)
    );
    qs_delay #(.W(24), .DEPTH(S_SIN+2-S_MAG)) u_dly_m (
        .i_clk, .i_en(en), .i_d(sqm_r[SQM_N][23:0]), .o_q(mag_sel)
    );

    assign st = ry[0][CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r67_ps0[i] <= 42'($signed(a_sin[i]) * ry[1][CORDIC_STEPS]);
                r67_ps1[i] <= 42'($signed(b_sin[i]) * ry[2][CORDIC_STEPS]);
                r68_n[i]   <= r67_ps0[i] + r67_ps1[i];
            end
            r67_st  <= st;
            r67_lin <= lin0_sin || st[CW-1] || (st == '0);
            r68_st  <= r67_st;
            r68_lin <= r67_lin;
            // A sine that is not positive or a dot near one takes the linear blend.
            for (int i = 0; i < 4; i++) begin
                r69_n[i] <= r68_lin ? NUMW'($signed({c_sel[i], 14'd0})) : r68_n[i];
            end
            r69_d    <= r68_lin ? mag_sel : r68_st[DW-1:0];
            r69_zero <= r68_lin && (mag_sel == '0);
        end
    end

    // ------------------------------------------------------------------
    // Rounded division: magnitude, half divisor, overflow check, then cells.
    // ------------------------------------------------------------------
    t_rem4         r70_abs;
    logic [3:0]    r70_neg;
    logic [DW-1:0] r70_d;
    logic          r70_zero;
    t_rem4         r71_num;
    logic [3:0]    r71_neg;
    logic [DW-1:0] r71_d;
    logic          r71_zero;
    t_rem4         r72_num;
    logic [DW-1:0] r72_d;
    t_div_flags    r72_fl;
    t_div_flags    fl_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r70_neg[i] <= r69_n[i][NUMW-1];
                r70_abs[i] <= r69_n[i][NUMW-1] ? (NUMW'(0) - r69_n[i]) : r69_n[i];
                r71_num[i] <= r70_abs[i] + NUMW'(r70_d >> 1);
                r72_fl.ovf[i] <= r71_num[i][NUMW-1:QW] >= (NUMW-QW)'(r71_d);
            end
            r70_d        <= r69_d;
            r70_zero     <= r69_zero;
            r71_neg      <= r70_neg;
            r71_d        <= r70_d;
            r71_zero     <= r70_zero;
            r72_num      <= r71_num;
            r72_d        <= r71_d;
            r72_fl.neg   <= r71_neg;
            r72_fl.zero  <= r71_zero;
        end
    end

    qs_delay #(.W($bits(t_div_flags)), .DEPTH(DIV_N)) u_dly_f (
        .i_clk, .i_en(en), .i_d(r72_fl), .o_q(fl_q)
    );

    t_rem4         dv_rem [DIV_N+1];
    t_quo4         dv_q   [DIV_N+1];
    logic [DW-1:0] dv_d   [DIV_N+1];

    assign dv_rem[0] = r72_num;
    assign dv_q[0]   = '0;
    assign dv_d[0]   = r72_d;

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        qs_div_cell #(.STEP(DIV_N-1-k)) u_cell (
            .i_clk, .i_en(en),
            .i_rem(dv_rem[k]), .i_q(dv_q[k]), .i_d(dv_d[k]),
            .o_rem(dv_rem[k+1]), .o_q(dv_q[k+1]), .o_d(dv_d[k+1])
        );
    end

    // Sign and saturation to the Q2.14 range.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                if (fl_q.zero) begin
                    r_tail[i] <= 16'd0;
                end else if (fl_q.ovf[i]) begin
                    r_tail[i] <= fl_q.neg[i] ? 16'h8000 : 16'h7FFF;
                end else if (!fl_q.neg[i]) begin
                    r_tail[i] <= (dv_q[DIV_N][i] > 17'd32767) ? 16'h7FFF
                                                              : dv_q[DIV_N][i][15:0];
                end else begin
                    r_tail[i] <= (dv_q[DIV_N][i] > 17'd32768) ? 16'h8000
                                                              : 16'(17'd0 - dv_q[DIV_N][i]);
                end
            end
        end
    end

`ifndef ASSERT_OFF
    // The skid register is only ever filled behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register holds an item while the output is empty");

    // A finished item meeting a stalled output must land in the skid register.
    a_tail_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && !r_sv && r_ov && !i_out_ready) |=> r_sv)
        else $error("finished item lost at a stalled output");

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");
`endif

endmodule

>>> rtl/qs_delay.sv
`timescale 1ns / 1ps
// Enabled shift line that carries payload alongside the cell chains.
// Depends on nothing.

module qs_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [DEPTH];

    // Each tap moves one place along whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

>>> rtl/qs_sqrt_cell.sv
`timescale 1ns / 1ps
// One step of the digit-by-digit integer square root, one result bit per cell.
// Depends on nothing.

module qs_sqrt_cell #(
    parameter int W     = 42,
    parameter int NSTEP = 21,
    parameter int STEP  = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_v,
    input  logic [W-1:0] i_r,
    output logic [W-1:0] o_v,
    output logic [W-1:0] o_r
);

    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (2 * (NSTEP - 1 - STEP));

    logic [W-1:0] trial;
    logic [W-1:0] n_v;
    logic [W-1:0] n_r;

    // Try the current bit against the remainder.
    always_comb begin
        trial = i_r + BIT;
        if (i_v >= trial) begin
            n_v = i_v - trial;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v <= n_v;
            o_r <= n_r;
        end
    end

endmodule

>>> rtl/qs_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC micro-rotation, in vectoring or rotation mode.
// Depends on qs_pkg for the widths and the arctangent table.

module qs_cordic_cell import qs_pkg::*; #(
    parameter int STEP      = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 up;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [ZW-1:0] n_z;

    // Vectoring drives y towards zero; rotation drives z towards zero.
    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        up = VECTORING ? !i_y[CW-1] : !i_z[ZW-1];
        if (VECTORING ? up : !up) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + C_ATAN[STEP];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - C_ATAN[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
        end
    end

endmodule

>>> rtl/qs_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step for all four lanes, giving one quotient bit each.
// Depends on qs_pkg for the lane types and widths.

module qs_div_cell import qs_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  t_rem4         i_rem,
    input  t_quo4         i_q,
    input  logic [DW-1:0] i_d,
    output t_rem4         o_rem,
    output t_quo4         o_q,
    output logic [DW-1:0] o_d
);

    logic [NUMW-1:0] dsh;
    t_rem4           n_rem;
    t_quo4           n_q;

    // Subtract the shifted divisor wherever it fits.
    always_comb begin
        dsh = NUMW'(i_d) << STEP;
        for (int i = 0; i < 4; i++) begin
            if (i_rem[i] >= dsh) begin
                n_rem[i] = i_rem[i] - dsh;
                n_q[i]   = i_q[i] | (QW'(1) << STEP);
            end else begin
                n_rem[i] = i_rem[i];
                n_q[i]   = i_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_q   <= n_q;
            o_d   <= i_d;
        end
    end

endmodule
